>>> hdl/lfpr_pkg.sv
package lfpr_pkg;

   // Frame geometry
   localparam logic [7:0] HEADER_LEN  = 8'd5;
   localparam logic [7:0] MAX_PAYLOAD = 8'd32;
   localparam logic [7:0] SIZE_POS    = 8'd4;

   localparam logic [7:0] CRC_FIRST = HEADER_LEN + MAX_PAYLOAD;
   localparam logic [7:0] CRC_LAST  = CRC_FIRST + 8'd1;
   localparam logic [7:0] FRAME_LEN = CRC_FIRST + 8'd2;

   // Position and end markers
   localparam logic [7:0] IDLE_POS = 8'd255;
   localparam logic [7:0] NO_END   = 8'd255;

   // Start countdown
   localparam logic [1:0] START_COUNT = 2'd2;

   // Buffer slots of the two start bytes and the byte that opens a packet
   localparam logic [5:0] SLOT_START  = 6'd0;
   localparam logic [5:0] SLOT_SECOND = 6'd1;
   localparam logic [5:0] SLOT_FIRST  = 6'd2;
   localparam logic [7:0] POS_AFTER_START = 8'd3;

   // Configuration register indexes and reset values
   localparam logic CSR_START_BYTE  = 1'b0;
   localparam logic CSR_SECOND_BYTE = 1'b1;
   localparam logic [7:0] START_BYTE_RST  = 8'd170;
   localparam logic [7:0] SECOND_BYTE_RST = 8'd85;

   // Beat numbers of a packet-start group
   localparam logic [1:0] BEAT_START  = 2'd0;
   localparam logic [1:0] BEAT_SECOND = 2'd1;
   localparam logic [1:0] BEAT_FIRST  = 2'd2;

   // Results of one received byte: either a packet start (three writes)
   // or a single result described by the write fields.
   typedef struct packed {
      logic       start;
      logic       write_valid;
      logic [5:0] write_index;
      logic [7:0] write_data;
      logic       packet_done;
      logic       frame_ready;
      logic [7:0] start_byte;
      logic [7:0] second_byte;
   } group_type;

endpackage

>>> hdl/lfpr_frame.sv
module lfpr_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            start_byte,
   input  logic [7:0]            second_byte,
   output lfpr_pkg::group_type   group
);

   logic [1:0] countdown_ff, countdown_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] payload_end_ff, payload_end_in;
   logic       ready_ff, ready_in;

   logic [7:0] pos;
   logic [7:0] pend;
   logic [7:0] wpos;

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff   <= lfpr_pkg::START_COUNT;
         position_ff    <= lfpr_pkg::IDLE_POS;
         payload_end_ff <= lfpr_pkg::NO_END;
         ready_ff       <= 1'b0;
      end else if (advance) begin
         countdown_ff   <= countdown_in;
         position_ff    <= position_in;
         payload_end_ff <= payload_end_in;
         ready_ff       <= ready_in;
      end
   end

   always_comb begin
      pos          = position_ff;
      pend         = payload_end_ff;
      countdown_in = lfpr_pkg::START_COUNT;
      wpos         = 8'd0;
      if (countdown_ff == 2'd0) begin
         pos  = 8'd0;
         pend = lfpr_pkg::NO_END;
      end else if (rx_byte == start_byte) begin
         countdown_in = countdown_ff - 2'd1;
      end

      position_in    = pos;
      payload_end_in = pend;
      ready_in       = ready_ff;

      group              = '0;
      group.start_byte   = start_byte;
      group.second_byte  = second_byte;
      group.write_data   = rx_byte;

      if (pos < lfpr_pkg::FRAME_LEN) begin
         if (pos == 8'd0) begin
            group.start = 1'b1;
            position_in = lfpr_pkg::POS_AFTER_START;
            ready_in    = 1'b0;
         end else if (pos == lfpr_pkg::CRC_LAST) begin
            group.write_valid = 1'b1;
            group.write_index = pos[5:0];
            group.packet_done = 1'b1;
            position_in       = lfpr_pkg::IDLE_POS;
            payload_end_in    = lfpr_pkg::NO_END;
            ready_in          = 1'b1;
         end else if (pos == lfpr_pkg::SIZE_POS) begin
            if (rx_byte > lfpr_pkg::MAX_PAYLOAD) begin
               // oversize: drop the frame
               position_in    = lfpr_pkg::IDLE_POS;
               payload_end_in = lfpr_pkg::NO_END;
               ready_in       = 1'b0;
            end else begin
               payload_end_in    = lfpr_pkg::HEADER_LEN + rx_byte;
               group.write_valid = 1'b1;
               group.write_index = pos[5:0];
               position_in       = pos + 8'd1;
            end
         end else begin
            wpos = (pos == pend) ? lfpr_pkg::CRC_FIRST : pos;
            group.write_valid = 1'b1;
            group.write_index = wpos[5:0];
            position_in       = wpos + 8'd1;
         end
      end

      if (!group.write_valid && !group.start) begin
         group.write_data = 8'd0;
      end
      group.frame_ready = ready_in;
   end

endmodule

>>> hdl/lfpr_emit.sv
module lfpr_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  lfpr_pkg::group_type   group,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_write_valid,
   output logic [5:0]            rsp_write_index,
   output logic [7:0]            rsp_write_data,
   output logic                  rsp_frame_ready,
   output logic                  rsp_packet_done,
   output logic                  rsp_last_result
);

   lfpr_pkg::group_type group_ff;
   logic       valid_ff, valid_in;
   logic [1:0] beat_ff, beat_in;
   logic       last;
   logic       load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= lfpr_pkg::BEAT_START;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group;
      end
   end

   always_comb begin
      last       = !group_ff.start || (beat_ff == lfpr_pkg::BEAT_FIRST);
      load_ready = !valid_ff || (rsp_ready && last);
      load       = load_valid && load_ready;
      valid_in   = valid_ff;
      beat_in    = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = lfpr_pkg::BEAT_START;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_in = 1'b0;
            beat_in  = lfpr_pkg::BEAT_START;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end

      rsp_valid       = valid_ff;
      rsp_frame_ready = group_ff.frame_ready;
      rsp_last_result = last;
      if (group_ff.start) begin
         rsp_write_valid = 1'b1;
         rsp_packet_done = 1'b0;
         case (beat_ff)
            lfpr_pkg::BEAT_START: begin
               rsp_write_index = lfpr_pkg::SLOT_START;
               rsp_write_data  = group_ff.start_byte;
            end
            lfpr_pkg::BEAT_SECOND: begin
               rsp_write_index = lfpr_pkg::SLOT_SECOND;
               rsp_write_data  = group_ff.second_byte;
            end
            default: begin
               rsp_write_index = lfpr_pkg::SLOT_FIRST;
               rsp_write_data  = group_ff.write_data;
            end
         endcase
      end else begin
         rsp_write_valid = group_ff.write_valid;
         rsp_write_index = group_ff.write_index;
         rsp_write_data  = group_ff.write_data;
         rsp_packet_done = group_ff.packet_done;
      end
   end

endmodule

>>> hdl/length_framed_packet_receiver.sv
// Length-framed packet receiver.
// req channel: one received serial byte per beat (req_rx_byte).
// rsp channel: buffer-write beats for an external packet buffer. Each beat
//   carries write enable, index and data, the frame-ready flag as it stands
//   after the byte, a done pulse on the final CRC byte, and rsp_last_result
//   on the last beat that a byte causes.
// csr channel: index 0 sets the start byte (reset 170), index 1 the second
//   header byte (reset 85); csr_ready is always high. Write while idle.
// Path: an accepted byte sits in the input register, its beats are formed
//   from it into the result register, and rsp presents them from there.
// Throughput: one byte per cycle for bytes giving one beat, while rsp_ready is
//   high; the byte that opens a packet gives three beats and holds the result
//   register until the third is taken, as the rsp port moves one beat per cycle.
// Reset: start countdown armed at 2, receiver idle, no payload end, ready
//   flag low, no beat pending, configuration at its reset values.
// Stall: with rsp_ready low the result register holds; the input register
//   still takes one more byte, then req_ready drops until beats drain.
module length_framed_packet_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_write_valid,
   output logic [5:0] rsp_write_index,
   output logic [7:0] rsp_write_data,
   output logic       rsp_frame_ready,
   output logic       rsp_packet_done,
   output logic       rsp_last_result,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0] start_byte_ff;
   logic [7:0] second_byte_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   logic       load_ready;
   logic       advance;
   lfpr_pkg::group_type group;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= lfpr_pkg::START_BYTE_RST;
         second_byte_ff <= lfpr_pkg::SECOND_BYTE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            lfpr_pkg::CSR_START_BYTE:  start_byte_ff  <= csr_wdata;
            lfpr_pkg::CSR_SECOND_BYTE: second_byte_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register: take a beat when empty or whenever the held byte moves on
   assign advance     = in_valid_ff && load_ready;
   assign req_ready   = !in_valid_ff || load_ready;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // framing state and decode of the held byte
   lfpr_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rx_byte     (in_byte_ff),
      .start_byte  (start_byte_ff),
      .second_byte (second_byte_ff),
      .group       (group)
   );

   // result register, one beat per cycle while rsp_ready is high
   lfpr_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (in_valid_ff),
      .load_ready       (load_ready),
      .group            (group),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_write_index  (rsp_write_index),
      .rsp_write_data   (rsp_write_data),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_packet_done  (rsp_packet_done),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

>>> tb/tb_length_framed_packet_receiver.sv
module tb_length_framed_packet_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import lfpr_pkg::*;

   // Give up well past the slowest legal run: ~400 bytes, three beats each,
   // every beat waiting out a long receiver stall, plus sender gaps.
   localparam int RUN_LIMIT = 400000;

   // One write beat as it appears on the rsp channel.
   typedef struct packed {
      logic       write_valid;
      logic [5:0] write_index;
      logic [7:0] write_data;
      logic       frame_ready;
      logic       packet_done;
      logic       last_result;
   } beat_type;

   // Directed row: the byte to send and, where it is obvious, the single beat
   // it must produce. Rows with known low are checked against the frame model.
   typedef struct packed {
      logic [7:0] rx;
      logic       known;
      beat_type   want;
   } row_type;

   localparam logic [5:0] CRC_LAST_SLOT = CRC_LAST[5:0];
   localparam beat_type QUIET_LOW  = '{1'b0, 6'd0, 8'd0, 1'b0, 1'b0, 1'b1};
   localparam beat_type QUIET_HIGH = '{1'b0, 6'd0, 8'd0, 1'b1, 1'b0, 1'b1};

   localparam int N_ROWS = 28;
   localparam row_type DIRECTED [N_ROWS] = '{
      // idle bytes at the value extremes, then arm the start countdown
      '{8'h00, 1'b1, QUIET_LOW},
      '{8'hFF, 1'b1, QUIET_LOW},
      '{START_BYTE_RST, 1'b1, QUIET_LOW},
      '{START_BYTE_RST, 1'b1, QUIET_LOW},
      // packet start, header byte, size 2, payload FF 00, CRC jump, done
      '{8'h01, 1'b0, '0},
      '{8'h7E, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h12, 1'b0, '0},
      '{8'h34, 1'b1, '{1'b1, CRC_LAST_SLOT, 8'h34, 1'b1, 1'b1, 1'b1}},
      // idle with the ready flag held high
      '{START_BYTE_RST, 1'b1, QUIET_HIGH},
      '{START_BYTE_RST, 1'b1, QUIET_HIGH},
      // packet whose payload holds two start bytes: restart on the next byte
      '{8'h80, 1'b0, '0},
      '{8'h03, 1'b0, '0},
      '{8'h04, 1'b0, '0},
      '{START_BYTE_RST, 1'b0, '0},
      '{START_BYTE_RST, 1'b0, '0},
      '{8'h11, 1'b0, '0},
      '{8'h22, 1'b0, '0},
      // oversize length aborts the restarted frame
      '{8'h21, 1'b1, QUIET_LOW},
      '{START_BYTE_RST, 1'b1, QUIET_LOW},
      '{START_BYTE_RST, 1'b1, QUIET_LOW},
      // zero-length payload: straight from the size byte to the CRC slots
      '{8'h55, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hC3, 1'b0, '0},
      '{8'h3C, 1'b1, '{1'b1, CRC_LAST_SLOT, 8'h3C, 1'b1, 1'b1, 1'b1}}
   };

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic       rsp_write_valid;
   logic [5:0] rsp_write_index;
   logic [7:0] rsp_write_data;
   logic       rsp_frame_ready;
   logic       rsp_packet_done;
   logic       rsp_last_result;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic       csr_index   = CSR_START_BYTE;
   logic [7:0] csr_wdata   = 8'd0;

   length_framed_packet_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_write_index  (rsp_write_index),
      .rsp_write_data   (rsp_write_data),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_packet_done  (rsp_packet_done),
      .rsp_last_result  (rsp_last_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Frame model state: its own copy of the configuration and the receiver.
   logic [7:0] cfg_start  = START_BYTE_RST;
   logic [7:0] cfg_second = SECOND_BYTE_RST;
   logic [1:0] arm_count  = START_COUNT;
   logic [7:0] wr_pos     = IDLE_POS;
   logic [7:0] pay_end    = NO_END;
   logic       rdy_flag   = 1'b0;

   beat_type byte_writes[$];   // beats of the byte just modeled
   beat_type writes_due[$];    // beats still owed by the receiver, oldest first

   int fails       = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int cycle_count = 0;
   int hold_left   = 0;

   function automatic void push_write(logic wv, logic [5:0] idx, logic [7:0] d,
                                      logic done);
      beat_type bt;
      bt = '{wv, idx, d, 1'b0, done, 1'b0};
      byte_writes.push_back(bt);
   endfunction

   // Work out the buffer writes one received byte causes and advance the model.
   function automatic void frame_writes(logic [7:0] b);
      logic [7:0] pos;
      byte_writes.delete();
      // The countdown runs on every byte, even inside a packet; the byte
      // after two start bytes opens a packet and is not itself counted.
      if (arm_count == 2'd0) begin
         arm_count = START_COUNT;
         wr_pos    = 8'd0;
         pay_end   = NO_END;
      end else if (b == cfg_start) begin
         arm_count = arm_count - 2'd1;
      end else begin
         arm_count = START_COUNT;
      end

      if (wr_pos < FRAME_LEN) begin
         pos = wr_pos;
         if (pos == 8'd0) begin
            push_write(1'b1, SLOT_START, cfg_start, 1'b0);
            push_write(1'b1, SLOT_SECOND, cfg_second, 1'b0);
            push_write(1'b1, SLOT_FIRST, b, 1'b0);
            wr_pos   = POS_AFTER_START;
            rdy_flag = 1'b0;
         end else if (pos == CRC_LAST) begin
            // CRC handling wins over the size slot
            push_write(1'b1, pos[5:0], b, 1'b1);
            wr_pos   = IDLE_POS;
            pay_end  = NO_END;
            rdy_flag = 1'b1;
         end else if (pos == SIZE_POS) begin
            if (b > MAX_PAYLOAD) begin
               wr_pos   = IDLE_POS;
               pay_end  = NO_END;
               rdy_flag = 1'b0;
            end else begin
               pay_end = HEADER_LEN + b;
               push_write(1'b1, pos[5:0], b, 1'b0);
               wr_pos = pos + 8'd1;
            end
         end else begin
            if (pos == pay_end)
               pos = CRC_FIRST;
            push_write(1'b1, pos[5:0], b, 1'b0);
            wr_pos = pos + 8'd1;
         end
      end

      if (byte_writes.size() == 0)
         push_write(1'b0, 6'd0, 8'd0, 1'b0);
      foreach (byte_writes[i]) begin
         byte_writes[i].frame_ready = rdy_flag;
         byte_writes[i].last_result = (i == byte_writes.size() - 1);
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endfunction

   // Drive one byte on req and hold it until taken. Queue its beats first, so
   // they are waiting long before the receiver can produce them. After the
   // beat, end the current burst with a random gap now and then.
   task automatic send_byte(logic [7:0] b, logic known, beat_type want);
      int gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      frame_writes(b);
      if (known)
         writes_due.push_back(want);
      else
         foreach (byte_writes[i]) writes_due.push_back(byte_writes[i]);
      items_sent++;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Hold the sender until every owed beat has come back, then let the
   // pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers back to back while the receiver is idle.
   task automatic write_config(logic [7:0] first, logic [7:0] second);
      csr_valid <= 1'b1;
      csr_index <= CSR_START_BYTE;
      csr_wdata <= first;
      do @(posedge clock); while (!csr_ready);
      cfg_start = first;
      csr_index <= CSR_SECOND_BYTE;
      csr_wdata <= second;
      do @(posedge clock); while (!csr_ready);
      cfg_second = second;
      csr_valid <= 1'b0;
   endtask

   // Receiver stall pattern: rotate, by bits 9:8 of the cycle counter, between always
   // ready, coin-flip ready, one cycle in four, and long on/off runs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (cycle_count[1:0] == 2'd0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= ~rsp_ready;
               hold_left <= $urandom_range(1, 12);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   // Compare every taken rsp beat with the oldest owed beat.
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (writes_due.size() == 0) begin
            $error("rsp beat with nothing owed: index %0d data %0h",
                   rsp_write_index, rsp_write_data);
            fails++;
         end else begin
            want = writes_due.pop_front();
            check_field("write_valid", 8'(want.write_valid), 8'(rsp_write_valid));
            check_field("write_index", 8'(want.write_index), 8'(rsp_write_index));
            check_field("write_data", want.write_data, rsp_write_data);
            check_field("frame_ready", 8'(want.frame_ready), 8'(rsp_frame_ready));
            check_field("packet_done", 8'(want.packet_done), 8'(rsp_packet_done));
            check_field("last_result", 8'(want.last_result), 8'(rsp_last_result));
         end
      end
   end

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int         noise;
      int         pick;
      logic [7:0] sz;
      logic [7:0] first_cfg;
      logic [7:0] second_cfg;
      bit         cut;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table on the reset configuration.
      for (int r = 0; r < N_ROWS; r++)
         send_byte(DIRECTED[r].rx, DIRECTED[r].known, DIRECTED[r].want);

      // Random phases: reset values first, then both extremes, then random.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph != 0) begin
            drain_results();
            case (ph)
               1: begin
                  first_cfg  = 8'h00;
                  second_cfg = 8'hFF;
               end
               2: begin
                  first_cfg  = 8'hFF;
                  second_cfg = 8'h00;
               end
               default: begin
                  first_cfg  = 8'($urandom_range(0, 255));
                  second_cfg = 8'($urandom_range(0, 255));
               end
            endcase
            write_config(first_cfg, second_cfg);
         end

         for (int n = items_sent + 80; items_sent < n; ) begin
            // Pause now and then until the receiver owes nothing.
            if ($urandom_range(0, 9) == 0)
               drain_results();

            // Line noise ahead of the frame.
            noise = $urandom_range(0, 3);
            repeat (noise) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);

            // Two start bytes, opening byte, header byte.
            send_byte(cfg_start, 1'b0, '0);
            send_byte(cfg_start, 1'b0, '0);
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0);

            // Mostly short payloads, some full size, some oversize.
            pick = $urandom_range(0, 99);
            if (pick < 8)
               sz = 8'($urandom_range(33, 255));
            else if (pick < 16)
               sz = MAX_PAYLOAD;
            else
               sz = 8'($urandom_range(0, 6));
            send_byte(sz, 1'b0, '0);

            if (sz <= MAX_PAYLOAD) begin
               cut = ($urandom_range(0, 19) == 0);
               for (int k = 0; k < sz; k++) begin
                  // Drop a start pair into the payload: forces a restart.
                  if ($urandom_range(0, 39) == 0) begin
                     send_byte(cfg_start, 1'b0, '0);
                     send_byte(cfg_start, 1'b0, '0);
                  end
                  send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
               end
               // Truncated frames skip the CRC and run into the next start.
               if (!cut) begin
                  send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                  send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
               end
            end
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fails == 0 && writes_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/lfpr_pkg.sv
hdl/lfpr_frame.sv
hdl/lfpr_emit.sv
hdl/length_framed_packet_receiver.sv
tb/tb_length_framed_packet_receiver.sv
